// ===== hw/rtl/tksd_pkg.sv =====
// ----------------------------------------------------------------------------
// Terminal key sequence decoder package
// Shared types, codes, key tables and sizes for the key decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;

  // Input event kinds.
  localparam logic EVT_BYTE    = 1'b0;
  localparam logic EVT_TIMEOUT = 1'b1;

  // Decode modes.
  localparam logic MODE_ANSI = 1'b0;
  localparam logic MODE_PC   = 1'b1;

  // Key numbers.
  localparam logic [7:0] KEY_UP    = 8'd0;
  localparam logic [7:0] KEY_DOWN  = 8'd1;
  localparam logic [7:0] KEY_LEFT  = 8'd2;
  localparam logic [7:0] KEY_RIGHT = 8'd3;
  localparam logic [7:0] KEY_HOME  = 8'd4;
  localparam logic [7:0] KEY_END   = 8'd5;
  localparam logic [7:0] KEY_PGUP  = 8'd6;
  localparam logic [7:0] KEY_PGDN  = 8'd7;
  localparam logic [7:0] KEY_INS   = 8'd8;
  localparam logic [7:0] KEY_DEL   = 8'd9;
  localparam logic [7:0] KEY_CHOME = 8'd10;
  localparam logic [7:0] KEY_CEND  = 8'd11;
  localparam logic [7:0] KEY_F1    = 8'd12;
  localparam logic [7:0] KEY_F5    = 8'd16;
  localparam logic [7:0] KEY_F8    = 8'd17;
  localparam logic [7:0] NO_KEY    = 8'd255;

  // Special bytes.
  localparam logic [7:0] BYTE_ESC    = 8'd27;
  localparam logic [7:0] BYTE_PC_E0  = 8'd224;
  localparam logic [7:0] BYTE_NUL    = 8'd0;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] BYTE_SS3    = 8'h4F;  // 'O'
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;  // '~'
  localparam logic [7:0] BYTE_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] BYTE_FIVE   = 8'h35;  // '5'
  localparam logic [7:0] BYTE_H      = 8'h48;  // 'H'
  localparam logic [7:0] BYTE_F      = 8'h46;  // 'F'
  localparam logic [3:0] DIGIT_HI    = 4'h3;   // upper nibble of ASCII digits

  // Result queue sizing; the depth is a power of two.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_ESC     = 4'd1,
    ST_CSI     = 4'd2,
    ST_SS3     = 4'd3,
    ST_CSI_DIG = 4'd4,
    ST_MOD     = 4'd5,
    ST_MOD2    = 4'd6,
    ST_FKEY    = 4'd7,
    ST_PREFIX  = 4'd8
  } parse_state_e;

  // One result item with its end-of-run flag.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } entry_t;

  // Results produced by one input item.
  typedef struct packed {
    logic [1:0] count;
    entry_t     first;
    entry_t     second;
  } decode_t;

  // Arrow, Home and End letters after ESC [ or ESC O.
  function automatic logic [7:0] letter_key(input logic [7:0] b);
    logic [7:0] k;
    case (b)
      8'h41:   k = KEY_UP;     // 'A'
      8'h42:   k = KEY_DOWN;   // 'B'
      8'h43:   k = KEY_RIGHT;  // 'C'
      8'h44:   k = KEY_LEFT;   // 'D'
      BYTE_H:  k = KEY_HOME;
      BYTE_F:  k = KEY_END;
      default: k = NO_KEY;
    endcase
    return k;
  endfunction

  // Editing keys of the form ESC [ digit ~, digit given as 0..9.
  function automatic logic [7:0] tilde_key(input logic [3:0] d);
    logic [7:0] k;
    case (d)
      4'd1, 4'd7: k = KEY_HOME;
      4'd2:       k = KEY_INS;
      4'd3:       k = KEY_DEL;
      4'd4, 4'd8: k = KEY_END;
      4'd5:       k = KEY_PGUP;
      4'd6:       k = KEY_PGDN;
      default:    k = NO_KEY;
    endcase
    return k;
  endfunction

  // Function keys of the form ESC [ 1 digit ~, digit given as 0..15.
  function automatic logic [7:0] fkey(input logic [3:0] d);
    logic [7:0] k;
    case (d)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5: k = KEY_F1 + {4'd0, d} - 8'd1;
      4'd9:                         k = KEY_F8;
      default:                      k = NO_KEY;
    endcase
    return k;
  endfunction

  // PC scan codes after a prefix byte.
  function automatic logic [7:0] scan_key(input logic [7:0] s);
    logic [7:0] k;
    case (s)
      8'd72:   k = KEY_UP;
      8'd80:   k = KEY_DOWN;
      8'd75:   k = KEY_LEFT;
      8'd77:   k = KEY_RIGHT;
      8'd71:   k = KEY_HOME;
      8'd79:   k = KEY_END;
      8'd73:   k = KEY_PGUP;
      8'd81:   k = KEY_PGDN;
      8'd82:   k = KEY_INS;
      8'd83:   k = KEY_DEL;
      8'd119:  k = KEY_CHOME;
      8'd117:  k = KEY_CEND;
      8'd63:   k = KEY_F5;
      8'd66:   k = KEY_F8;
      default: k = NO_KEY;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/tksd_in_if.sv =====
// ----------------------------------------------------------------------------
// Key decoder input channel
// Valid/ready channel carrying one received byte or a timeout event.
// ----------------------------------------------------------------------------
interface tksd_in_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] in_byte;

  modport source (output valid, output event_kind, output in_byte, input ready);
  modport sink   (input valid, input event_kind, input in_byte, output ready);
endinterface

// ===== hw/rtl/tksd_out_if.sv =====
// ----------------------------------------------------------------------------
// Key decoder output channel
// Valid/ready channel carrying one decoded character, key or idle event.
// ----------------------------------------------------------------------------
interface tksd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] result_value;
  logic       last_of_run;

  modport source (output valid, output result_kind, output result_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input result_value,
                  input last_of_run, output ready);
endinterface

// ===== hw/rtl/tksd_decoder.sv =====
// ----------------------------------------------------------------------------
// Key decoder parser
// Holds the parse state and decodes one registered input item per cycle,
// while the result queue has room, into zero, one or two result items.
// ----------------------------------------------------------------------------
module tksd_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              consume_i,
  input  logic              event_kind_i,
  input  logic [7:0]        in_byte_i,
  output tksd_pkg::decode_t dec_o
);

  tksd_pkg::parse_state_e state_q, state_d;
  logic [3:0] held_digit_q, held_digit_d;
  logic       modifier_ok_q, modifier_ok_d;
  logic       mode_q;

  logic       timeout;
  logic [7:0] b;
  logic [7:0] key;
  logic [1:0] n;
  logic [1:0] kind0, kind1;
  logic [7:0] val0, val1;

  assign timeout = (event_kind_i == tksd_pkg::EVT_TIMEOUT);
  assign b       = in_byte_i;

  // Parse state, held digit, modifier flag and mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= tksd_pkg::ST_IDLE;
      held_digit_q  <= 4'd0;
      modifier_ok_q <= 1'b0;
      mode_q        <= tksd_pkg::MODE_ANSI;
    end else if (cfg_we_i) begin
      state_q       <= tksd_pkg::ST_IDLE;
      held_digit_q  <= 4'd0;
      modifier_ok_q <= 1'b0;
      mode_q        <= cfg_wdata_i;
    end else if (consume_i) begin
      state_q       <= state_d;
      held_digit_q  <= held_digit_d;
      modifier_ok_q <= modifier_ok_d;
    end
  end

  // Next state and results for the item at the head of the input register.
  always_comb begin
    state_d       = tksd_pkg::ST_IDLE;
    held_digit_d  = held_digit_q;
    modifier_ok_d = modifier_ok_q;
    n             = 2'd0;
    kind0         = tksd_pkg::KIND_CHAR;
    val0          = tksd_pkg::BYTE_ESC;
    kind1         = tksd_pkg::KIND_CHAR;
    val1          = b;
    key           = tksd_pkg::NO_KEY;

    if (state_q == tksd_pkg::ST_PREFIX) begin
      if (timeout) begin
        // A timeout after a prefix byte is ignored.
        state_d = tksd_pkg::ST_PREFIX;
      end else begin
        key = tksd_pkg::scan_key(b);
        n   = 2'd1;
        if (key == tksd_pkg::NO_KEY) begin
          val0 = tksd_pkg::BYTE_NUL;
        end else begin
          kind0 = tksd_pkg::KIND_KEY;
          val0  = key;
        end
      end
    end else if (state_q == tksd_pkg::ST_IDLE || state_q > tksd_pkg::ST_FKEY) begin
      if (timeout) begin
        n     = 2'd1;
        kind0 = tksd_pkg::KIND_IDLE;
        val0  = 8'd0;
      end else if (mode_q == tksd_pkg::MODE_PC &&
                   (b == tksd_pkg::BYTE_NUL || b == tksd_pkg::BYTE_PC_E0)) begin
        state_d = tksd_pkg::ST_PREFIX;
      end else if (mode_q == tksd_pkg::MODE_ANSI && b == tksd_pkg::BYTE_ESC) begin
        state_d = tksd_pkg::ST_ESC;
      end else begin
        n    = 2'd1;
        val0 = b;
      end
    end else if (timeout) begin
      // A cut-off sequence yields ESC alone.
      n = 2'd1;
    end else begin
      case (state_q)
        tksd_pkg::ST_ESC: begin
          if (b == tksd_pkg::BYTE_LBRACK) begin
            state_d = tksd_pkg::ST_CSI;
          end else if (b == tksd_pkg::BYTE_SS3) begin
            state_d = tksd_pkg::ST_SS3;
          end else begin
            n = 2'd2;
          end
        end
        tksd_pkg::ST_CSI: begin
          if (b[7:4] == tksd_pkg::DIGIT_HI && b[3:0] <= 4'd9) begin
            held_digit_d = b[3:0];
            state_d      = tksd_pkg::ST_CSI_DIG;
          end else begin
            key = tksd_pkg::letter_key(b);
            n   = 2'd1;
          end
        end
        tksd_pkg::ST_SS3: begin
          key = tksd_pkg::letter_key(b);
          n   = 2'd1;
        end
        tksd_pkg::ST_CSI_DIG: begin
          if (b == tksd_pkg::BYTE_TILDE) begin
            key = tksd_pkg::tilde_key(held_digit_q);
            n   = 2'd1;
          end else if (b == tksd_pkg::BYTE_SEMI) begin
            state_d = tksd_pkg::ST_MOD;
          end else if (held_digit_q == 4'd1 && b[7:4] == tksd_pkg::DIGIT_HI &&
                       tksd_pkg::fkey(b[3:0]) != tksd_pkg::NO_KEY) begin
            held_digit_d = b[3:0];
            state_d      = tksd_pkg::ST_FKEY;
          end else begin
            n = 2'd1;
          end
        end
        tksd_pkg::ST_MOD: begin
          modifier_ok_d = (b == tksd_pkg::BYTE_FIVE);
          state_d       = tksd_pkg::ST_MOD2;
        end
        tksd_pkg::ST_MOD2: begin
          n = 2'd1;
          if (modifier_ok_q && b == tksd_pkg::BYTE_H) begin
            key = tksd_pkg::KEY_CHOME;
          end else if (modifier_ok_q && b == tksd_pkg::BYTE_F) begin
            key = tksd_pkg::KEY_CEND;
          end
        end
        tksd_pkg::ST_FKEY: begin
          n = 2'd1;
          if (b == tksd_pkg::BYTE_TILDE) begin
            key = tksd_pkg::fkey(held_digit_q);
          end
        end
        default: begin
          n = 2'd1;
        end
      endcase
      // A known key replaces the default ESC result.
      if (key != tksd_pkg::NO_KEY) begin
        kind0 = tksd_pkg::KIND_KEY;
        val0  = key;
      end
    end
  end

  // Pack the results with the end-of-run flag on the final one.
  always_comb begin
    dec_o.count        = consume_i ? n : 2'd0;
    dec_o.first.kind   = kind0;
    dec_o.first.value  = val0;
    dec_o.first.last   = (n == 2'd1);
    dec_o.second.kind  = kind1;
    dec_o.second.value = val1;
    dec_o.second.last  = 1'b1;
  end

`ifndef SYNTH
  // Two results only ever come from ESC followed by an ordinary byte.
  a_pair_starts_with_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.count == 2'd2 |-> state_q == tksd_pkg::ST_ESC &&
      dec_o.first.kind == tksd_pkg::KIND_CHAR && dec_o.first.value == tksd_pkg::BYTE_ESC)
    else $error("two results without a pending ESC");

  // A timeout after a PC prefix keeps the scan code pending.
  a_prefix_survives_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume_i && !cfg_we_i && state_q == tksd_pkg::ST_PREFIX && timeout
    |=> state_q == tksd_pkg::ST_PREFIX)
    else $error("prefix state lost on timeout");

  // An escape sequence can only begin in ANSI mode.
  a_esc_only_in_ansi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tksd_pkg::ST_ESC |-> mode_q == tksd_pkg::MODE_ANSI)
    else $error("escape parsing in PC mode");
`endif

endmodule

// ===== hw/rtl/tksd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Key decoder result queue
// Small register queue that takes up to two result items per cycle and
// hands one item per cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module tksd_result_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tksd_pkg::decode_t       push_i,
  input  logic                    pop_i,
  output logic                    valid_o,
  output tksd_pkg::entry_t        head_o,
  output logic [tksd_pkg::CntW-1:0] count_o
);

  tksd_pkg::entry_t mem_q [tksd_pkg::FifoDepth];
  logic [tksd_pkg::PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [tksd_pkg::PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [tksd_pkg::CntW-1:0] count_q, count_d;
  logic [tksd_pkg::PtrW-1:0] wr_ptr_nxt;
  logic                      pop;

  assign pop        = pop_i && (count_q != '0);
  assign wr_ptr_nxt = wr_ptr_q + tksd_pkg::PtrW'(1);

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + tksd_pkg::PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + tksd_pkg::PtrW'(pop);
    count_d  = count_q + tksd_pkg::CntW'(push_i.count) - tksd_pkg::CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage: the first result goes to the write pointer, the second after it.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.second;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

`ifndef SYNTH
  // The fill level never passes the depth.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tksd_pkg::CntW'(tksd_pkg::FifoDepth))
    else $error("result queue overflow");

  // The fill level tracks pushes and pops exactly.
  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + tksd_pkg::CntW'($past(push_i.count))
                        - tksd_pkg::CntW'($past(pop)))
    else $error("result queue count mismatch");

  // The write pointer stays the read pointer plus the fill level.
  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ptr_q == rd_ptr_q + tksd_pkg::PtrW'(count_q))
    else $error("result queue pointers inconsistent");
`endif

endmodule

// ===== hw/rtl/terminal_key_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// Terminal key sequence decoder
// Decodes keyboard bytes and timeout events into characters and keys, in
// ANSI escape-sequence mode or PC scan-code mode.
// ----------------------------------------------------------------------------
// The first result of an item passes through the input register and then
// the result queue before the output channel offers it.
// Throughput: one item per cycle while results are taken at one per cycle;
// the single output port limits how often items that give two results can
// be taken. Input stalls when the four-entry result queue lacks two slots.
// Reset: asynchronous, active low; ANSI mode, parser idle, result queue and input register empty.
module terminal_key_sequence_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  tksd_in_if.sink    in_if,
  tksd_out_if.source out_if
);

  logic                      in_valid_q;
  logic                      event_kind_q;
  logic [7:0]                in_byte_q;
  logic                      consume;
  logic [tksd_pkg::CntW-1:0] fifo_count;
  tksd_pkg::decode_t         dec;
  tksd_pkg::entry_t          head;

  // The registered item is decoded once the queue has room for two results.
  assign consume     = in_valid_q &&
                       (fifo_count <= tksd_pkg::CntW'(tksd_pkg::FifoDepth - 2));
  assign in_if.ready = !in_valid_q || consume;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      event_kind_q <= in_if.event_kind;
      in_byte_q    <= in_if.in_byte;
    end
  end

  tksd_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .consume_i    (consume),
    .event_kind_i (event_kind_q),
    .in_byte_i    (in_byte_q),
    .dec_o        (dec)
  );

  tksd_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dec),
    .pop_i   (out_if.ready),
    .valid_o (out_if.valid),
    .head_o  (head),
    .count_o (fifo_count)
  );

  // Output channel payload.
  assign out_if.result_kind  = head.kind;
  assign out_if.result_value = head.value;
  assign out_if.last_of_run  = head.last;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Terminal key sequence decoder testbench
// Sends bytes and timeout events through the input channel, predicts the
// decoded characters and keys in step with the block, and checks every
// result item in order. A short table of hand-picked items comes first,
// then random key sequences in both decode modes, with random gaps on both
// channels, a stretch without gaps and long output stalls.
// ----------------------------------------------------------------------------
module tb;
  import tksd_pkg::*;

  localparam int HALF_NS       = 10;
  localparam int RESET_CYCLES  = 5;
  localparam int IDLE_PCT      = 31;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 188;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_MAX    = 10;
  localparam int LIMIT_NS      = 4_000_000;

  // Printable bytes not named in the package.
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_B  = 8'h42;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] SC_UP = 8'd72;

  // Pools that random sequences draw their well-formed bytes from.
  localparam logic [47:0]  ARROW_LETTERS = {CH_A, CH_B, CH_C, CH_D, BYTE_H, BYTE_F};
  localparam logic [47:0]  FN_DIGITS     = {8'h31, 8'h32, 8'h33, 8'h34, 8'h35, CH_9};
  localparam logic [111:0] SCAN_CODES    = {8'd72, 8'd80, 8'd75, 8'd77, 8'd71, 8'd79,
                                            8'd73, 8'd81, 8'd82, 8'd83, 8'd119, 8'd117,
                                            8'd63, 8'd66};

  // Decode mode of each random phase, last phase first.
  localparam logic [PHASES-1:0] PHASE_MODES = {MODE_PC, MODE_ANSI, MODE_ANSI,
                                               MODE_PC, MODE_ANSI, MODE_PC};

  localparam decode_t NO_RESULT = '0;
  localparam logic    TYPED     = 1'b1;
  localparam logic    PREDICTED = 1'b0;

  typedef enum logic [1:0] {ROW_BYTE, ROW_TIMEOUT, ROW_MODE} row_op_e;

  // One line of the directed table.
  typedef struct packed {
    row_op_e    op;
    logic [7:0] data;
    logic       typed;
    decode_t    want;
  } row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic cfg_wdata_i;

  tksd_in_if  in_ch ();
  tksd_out_if out_ch ();

  terminal_key_sequence_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always begin
    #HALF_NS clk_i = 1'b1;
    #HALF_NS clk_i = 1'b0;
  end

  // Predicted decoder state.
  parse_state_e pstate;
  logic         mode_pc;
  logic [7:0]   held_code;
  logic         five_seen;

  // Decoded results still to arrive, oldest first.
  entry_t due_results[$];

  // Bytes and timeouts of the sequence about to be sent, as {event, byte}.
  logic [8:0] burst_q[$];

  // Gap control shared by the two channel processes.
  logic quiet      = 1'b0;
  logic hold_token = 1'b0;
  logic rx_holding = 1'b0;

  int n_items   = 0;
  int n_writes  = 0;
  int n_checked = 0;
  int n_keys    = 0;
  int n_chars   = 0;
  int n_idles   = 0;
  int n_errors  = 0;

  // Result helpers.
  function automatic decode_t single_result(input logic [1:0] kind, input logic [7:0] value);
    decode_t d;
    d = '0;
    d.count = 2'd1;
    d.first = {kind, value, 1'b1};
    return d;
  endfunction

  function automatic decode_t esc_then(input logic [7:0] b);
    decode_t d;
    d.count  = 2'd2;
    d.first  = {KIND_CHAR, BYTE_ESC, 1'b0};
    d.second = {KIND_CHAR, b, 1'b1};
    return d;
  endfunction

  function automatic decode_t key_or_esc(input logic [7:0] k);
    return (k == NO_KEY) ? single_result(KIND_CHAR, BYTE_ESC) : single_result(KIND_KEY, k);
  endfunction

  // Final letter after ESC [ or ESC O.
  function automatic logic [7:0] arrow_code(input logic [7:0] b);
    logic [7:0] k;
    case (b)
      CH_A:    k = KEY_UP;
      CH_B:    k = KEY_DOWN;
      CH_C:    k = KEY_RIGHT;
      CH_D:    k = KEY_LEFT;
      BYTE_H:  k = KEY_HOME;
      BYTE_F:  k = KEY_END;
      default: k = NO_KEY;
    endcase
    return k;
  endfunction

  // ASCII digit of ESC [ digit ~.
  function automatic logic [7:0] edit_code(input logic [7:0] d);
    logic [7:0] k;
    case (d)
      8'h31, 8'h37: k = KEY_HOME;
      8'h32:        k = KEY_INS;
      8'h33:        k = KEY_DEL;
      8'h34, 8'h38: k = KEY_END;
      8'h35:        k = KEY_PGUP;
      8'h36:        k = KEY_PGDN;
      default:      k = NO_KEY;
    endcase
    return k;
  endfunction

  // ASCII digit of ESC [ 1 digit ~.
  function automatic logic [7:0] fn_code(input logic [7:0] d);
    if (d >= CH_1 && d <= 8'h35) return KEY_F1 + (d - CH_1);
    if (d == CH_9) return KEY_F8;
    return NO_KEY;
  endfunction

  function automatic logic [7:0] scan_code(input logic [7:0] s);
    logic [7:0] k;
    case (s)
      8'd72:   k = KEY_UP;
      8'd80:   k = KEY_DOWN;
      8'd75:   k = KEY_LEFT;
      8'd77:   k = KEY_RIGHT;
      8'd71:   k = KEY_HOME;
      8'd79:   k = KEY_END;
      8'd73:   k = KEY_PGUP;
      8'd81:   k = KEY_PGDN;
      8'd82:   k = KEY_INS;
      8'd83:   k = KEY_DEL;
      8'd119:  k = KEY_CHOME;
      8'd117:  k = KEY_CEND;
      8'd63:   k = KEY_F5;
      8'd66:   k = KEY_F8;
      default: k = NO_KEY;
    endcase
    return k;
  endfunction

  // Advances the predicted parser by one item and returns its results.
  function automatic decode_t decode_event(input logic evt, input logic [7:0] b);
    decode_t      r;
    logic [7:0]   k;
    parse_state_e st;
    r  = NO_RESULT;
    st = pstate;
    if (st == ST_PREFIX) begin
      // A timeout after a prefix byte leaves the scan code pending.
      if (evt == EVT_BYTE) begin
        k = scan_code(b);
        r = (k == NO_KEY) ? single_result(KIND_CHAR, BYTE_NUL) : single_result(KIND_KEY, k);
        pstate = ST_IDLE;
      end
    end else if (st == ST_IDLE || st > ST_FKEY) begin
      pstate = ST_IDLE;
      if (evt == EVT_TIMEOUT) begin
        r = single_result(KIND_IDLE, 8'h00);
      end else if (mode_pc == MODE_PC && (b == BYTE_NUL || b == BYTE_PC_E0)) begin
        pstate = ST_PREFIX;
      end else if (mode_pc == MODE_ANSI && b == BYTE_ESC) begin
        pstate = ST_ESC;
      end else begin
        r = single_result(KIND_CHAR, b);
      end
    end else if (evt == EVT_TIMEOUT) begin
      // A timeout inside a sequence gives up on it.
      r = single_result(KIND_CHAR, BYTE_ESC);
      pstate = ST_IDLE;
    end else begin
      pstate = ST_IDLE;
      case (st)
        ST_ESC: begin
          if (b == BYTE_LBRACK) pstate = ST_CSI;
          else if (b == BYTE_SS3) pstate = ST_SS3;
          else r = esc_then(b);
        end
        ST_CSI: begin
          if (b >= CH_0 && b <= CH_9) begin
            held_code = b;
            pstate = ST_CSI_DIG;
          end else begin
            r = key_or_esc(arrow_code(b));
          end
        end
        ST_SS3: begin
          r = key_or_esc(arrow_code(b));
        end
        ST_CSI_DIG: begin
          if (b == BYTE_TILDE) begin
            r = key_or_esc(edit_code(held_code));
          end else if (b == BYTE_SEMI) begin
            pstate = ST_MOD;
          end else if (held_code == CH_1 && fn_code(b) != NO_KEY) begin
            held_code = b;
            pstate = ST_FKEY;
          end else begin
            r = single_result(KIND_CHAR, BYTE_ESC);
          end
        end
        ST_MOD: begin
          five_seen = (b == BYTE_FIVE);
          pstate = ST_MOD2;
        end
        ST_MOD2: begin
          if (five_seen && b == BYTE_H) r = single_result(KIND_KEY, KEY_CHOME);
          else if (five_seen && b == BYTE_F) r = single_result(KIND_KEY, KEY_CEND);
          else r = single_result(KIND_CHAR, BYTE_ESC);
        end
        default: begin
          if (b == BYTE_TILDE) r = key_or_esc(fn_code(held_code));
          else r = single_result(KIND_CHAR, BYTE_ESC);
        end
      endcase
    end
    return r;
  endfunction

  function automatic row_t step_row(input row_op_e op, input logic [7:0] data,
                                    input logic typed, input decode_t want);
    row_t t;
    t.op    = op;
    t.data  = data;
    t.typed = typed;
    t.want  = want;
    return t;
  endfunction

  // Returns the given byte most of the time, otherwise any byte.
  function automatic logic [7:0] mostly(input logic [7:0] b);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    return ($urandom_range(0, 99) < 80) ? b : r;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    burst_q.push_back({EVT_BYTE, b});
  endtask

  task automatic add_timeout();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    burst_q.push_back({EVT_TIMEOUT, junk});
  endtask

  task automatic queue_results(input decode_t d);
    if (d.count != 2'd0) due_results.push_back(d.first);
    if (d.count == 2'd2) due_results.push_back(d.second);
  endtask

  // Offers one item, after a random gap unless gaps are off or the output side is holding, and waits until it is taken.
  task automatic send_item(input logic evt, input logic [7:0] b, output decode_t got);
    if (!quiet && !rx_holding) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.event_kind <= evt;
    in_ch.in_byte    <= b;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    got = decode_event(evt, b);
    n_items++;
  endtask

  // Lets every expected result drain, then a few cycles for result-free items.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    // A write also drops any sequence in progress.
    mode_pc   = m;
    pstate    = ST_IDLE;
    held_code = 8'h00;
    five_seen = 1'b0;
    n_writes++;
  endtask

  // Random ANSI traffic: mostly well-formed escape sequences.
  task automatic build_ansi_burst();
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 28) begin
      add_timeout();
    end else begin
      add_byte(BYTE_ESC);
      if (pick < 44) begin
        idx = $urandom_range(0, 5);
        add_byte($urandom_range(0, 1) ? BYTE_LBRACK : BYTE_SS3);
        add_byte(mostly(ARROW_LETTERS[8*idx +: 8]));
      end else if (pick < 58) begin
        add_byte(BYTE_LBRACK);
        add_byte(CH_0 + 8'($urandom_range(0, 9)));
        add_byte(mostly(BYTE_TILDE));
      end else if (pick < 72) begin
        add_byte(BYTE_LBRACK);
        add_byte(mostly(CH_1));
        add_byte(BYTE_SEMI);
        add_byte(mostly(BYTE_FIVE));
        add_byte(mostly($urandom_range(0, 1) ? BYTE_H : BYTE_F));
      end else if (pick < 86) begin
        idx = $urandom_range(0, 5);
        add_byte(BYTE_LBRACK);
        add_byte(CH_1);
        add_byte(mostly(FN_DIGITS[8*idx +: 8]));
        add_byte(mostly(BYTE_TILDE));
      end else begin
        // Lone ESC, ESC ESC, ESC with a stray byte, or ESC cut off by a timeout.
        case ($urandom_range(0, 3))
          0:       ;
          1:       add_byte(BYTE_ESC);
          2:       add_byte(8'($urandom_range(0, 255)));
          default: add_timeout();
        endcase
      end
    end
  endtask

  // Random PC traffic: mostly prefix byte plus scan code.
  task automatic build_pc_burst();
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 32) begin
      add_timeout();
    end else begin
      idx = $urandom_range(0, 13);
      add_byte($urandom_range(0, 1) ? BYTE_PC_E0 : BYTE_NUL);
      if ($urandom_range(0, 99) < 15) add_timeout();
      add_byte(($urandom_range(0, 3) != 0) ? SCAN_CODES[8*idx +: 8]
                                           : 8'($urandom_range(0, 255)));
    end
  endtask

  // Sends the built sequence, now and then damaging or cutting its tail.
  task automatic play_burst();
    decode_t    got;
    logic [8:0] it;
    int         i;
    int         r;
    logic       cut;
    cut = 1'b0;
    for (i = 0; i < burst_q.size() && !cut; i++) begin
      it = burst_q[i];
      r  = $urandom_range(0, 99);
      if (i > 0 && r < 3) begin
        it[7:0] = 8'($urandom_range(0, 255));
      end else if (i > 0 && r < 6) begin
        it[8] = EVT_TIMEOUT;
      end else if (i > 0 && r < 9) begin
        cut = 1'b1;
      end
      if (!cut) begin
        send_item(it[8], it[7:0], got);
        queue_results(got);
      end
    end
    burst_q.delete();
  endtask

  // Output side: checks each result item and stalls at random or on request.
  initial begin : result_side
    entry_t seen;
    entry_t want;
    int     hold_left;
    logic   token_seen;
    hold_left  = 0;
    token_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen = {out_ch.result_kind, out_ch.result_value, out_ch.last_of_run};
        n_checked++;
        if (seen.kind == KIND_KEY) n_keys++;
        else if (seen.kind == KIND_IDLE) n_idles++;
        else n_chars++;
        if (due_results.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display("Unexpected result %0d: kind %0d value %0d last %0d",
                     n_checked, seen.kind, seen.value, seen.last);
        end else begin
          want = due_results.pop_front();
          if (seen.kind !== want.kind || seen.value !== want.value ||
              seen.last !== want.last) begin
            n_errors++;
            if (n_errors <= REPORT_MAX)
              $display({"Mismatch on result %0d: expected kind %0d value %0d last %0d,",
                        " got kind %0d value %0d last %0d"},
                       n_checked, want.kind, want.value, want.last,
                       seen.kind, seen.value, seen.last);
          end
        end
      end
      // A change of the hold token starts a long stall.
      if (hold_token != token_seen) begin
        token_seen = hold_token;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
        rx_holding   <= 1'b1;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        rx_holding   <= 1'b0;
      end
    end
  end

  // Input side: directed table, then random phases in both modes.
  initial begin : stimulus
    row_t    plan[$];
    decode_t got;
    int      start;
    int      n_directed;
    int      ph;

    in_ch.valid      <= 1'b0;
    in_ch.event_kind <= EVT_BYTE;
    in_ch.in_byte    <= 8'h00;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= MODE_ANSI;
    mode_pc   = MODE_ANSI;
    pstate    = ST_IDLE;
    held_code = 8'h00;
    five_seen = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Byte extremes and an idle timeout straight after reset.
    plan.push_back(step_row(ROW_BYTE,    BYTE_NUL,    TYPED,     single_result(KIND_CHAR, BYTE_NUL)));
    plan.push_back(step_row(ROW_BYTE,    8'hFF,       TYPED,     single_result(KIND_CHAR, 8'hFF)));
    plan.push_back(step_row(ROW_TIMEOUT, 8'hA5,       TYPED,     single_result(KIND_IDLE, 8'h00)));
    // ESC followed by ESC.
    plan.push_back(step_row(ROW_BYTE,    BYTE_ESC,    TYPED,     NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    BYTE_ESC,    TYPED,     esc_then(BYTE_ESC)));
    // ESC O H gives Home.
    plan.push_back(step_row(ROW_BYTE,    BYTE_ESC,    PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    BYTE_SS3,    PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    BYTE_H,      TYPED,     single_result(KIND_KEY, KEY_HOME)));
    // Unknown digit before the tilde.
    plan.push_back(step_row(ROW_BYTE,    BYTE_ESC,    PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    BYTE_LBRACK, PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    CH_0,        PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    BYTE_TILDE,  TYPED,     single_result(KIND_CHAR, BYTE_ESC)));
    // Modifier other than five still eats the final letter.
    plan.push_back(step_row(ROW_BYTE,    BYTE_ESC,    PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    BYTE_LBRACK, PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    CH_1,        PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    BYTE_SEMI,   PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    CH_9,        PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    BYTE_H,      TYPED,     single_result(KIND_CHAR, BYTE_ESC)));
    // Timeout in the middle of a sequence.
    plan.push_back(step_row(ROW_BYTE,    BYTE_ESC,    PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    BYTE_LBRACK, PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_TIMEOUT, 8'h00,       TYPED,     single_result(KIND_CHAR, BYTE_ESC)));
    // A lone ESC left pending when the mode changes.
    plan.push_back(step_row(ROW_BYTE,    BYTE_ESC,    PREDICTED, NO_RESULT));
    plan.push_back(step_row(ROW_MODE,    {7'd0, MODE_PC},   TYPED, NO_RESULT));
    // Timeout after a prefix byte is ignored; unknown scan code gives NUL.
    plan.push_back(step_row(ROW_BYTE,    BYTE_PC_E0,  TYPED,     NO_RESULT));
    plan.push_back(step_row(ROW_TIMEOUT, 8'h5A,       TYPED,     NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    SC_UP,       TYPED,     single_result(KIND_KEY, KEY_UP)));
    plan.push_back(step_row(ROW_BYTE,    BYTE_NUL,    TYPED,     NO_RESULT));
    plan.push_back(step_row(ROW_BYTE,    8'h01,       TYPED,     single_result(KIND_CHAR, BYTE_NUL)));
    plan.push_back(step_row(ROW_MODE,    {7'd0, MODE_ANSI}, TYPED, NO_RESULT));

    foreach (plan[i]) begin
      if (plan[i].op == ROW_MODE) begin
        settle();
        write_mode(plan[i].data[0]);
      end else begin
        send_item((plan[i].op == ROW_TIMEOUT) ? EVT_TIMEOUT : EVT_BYTE, plan[i].data, got);
        queue_results(plan[i].typed ? plan[i].want : got);
      end
    end
    n_directed = n_items;

    // Random phases; the fourth runs without gaps, two start with a long stall.
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      write_mode(PHASE_MODES[ph]);
      quiet <= (ph == 3);
      if (ph == 1 || ph == 4) hold_token <= ~hold_token;
      start = n_items;
      while (n_items - start < PHASE_ITEMS) begin
        if (mode_pc == MODE_PC) build_pc_burst();
        else build_ansi_burst();
        play_burst();
      end
      // Sometimes leave a sequence open across the mode write.
      if (mode_pc == MODE_ANSI && $urandom_range(0, 1) == 1) begin
        send_item(EVT_BYTE, BYTE_ESC, got);
        queue_results(got);
      end
    end
    settle();

    $display("Decoder run: %0d items (%0d from the table), %0d mode writes, %0d results checked.",
             n_items, n_directed, n_writes, n_checked);
    $display("Results seen: %0d keys, %0d characters, %0d idle events; %0d failures.",
             n_keys, n_chars, n_idles, n_errors);
    if (n_errors == 0 && due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #LIMIT_NS;
    $display("Timed out with %0d results outstanding.", due_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tksd_pkg.sv
hw/rtl/tksd_in_if.sv
hw/rtl/tksd_out_if.sv
hw/rtl/tksd_decoder.sv
hw/rtl/tksd_result_fifo.sv
hw/rtl/terminal_key_sequence_decoder.sv
sim/tb.sv
